// ===== rtl/core/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);

  localparam logic [31:0] ResetMaxRequest = 32'd100000000;
  localparam logic [7:0] ResetHeaderBytes = 8'd40;
  localparam logic [31:0] ResetHeapLimit = 32'd1048576;

  localparam logic [1:0] CfgMaxRequest = 2'd0;
  localparam logic [1:0] CfgHeaderBytes = 2'd1;
  localparam logic [1:0] CfgHeapLimit = 2'd2;

  localparam logic [1:0] KindAlloc = 2'd0;
  localparam logic [1:0] KindFree = 2'd1;
  localparam logic [1:0] KindRealloc = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  localparam logic [2:0] StReused = 3'd0;
  localparam logic [2:0] StAppended = 3'd1;
  localparam logic [2:0] StKept = 3'd2;
  localparam logic [2:0] StFreed = 3'd3;
  localparam logic [2:0] StBadSize = 3'd4;
  localparam logic [2:0] StExhausted = 3'd5;
  localparam logic [2:0] StTableFull = 3'd6;
  localparam logic [2:0] StNotFound = 3'd7;

  // Token that travels down the chain of cells during a scan.
  typedef struct packed {
    logic        valid;
    logic        find_fit;   // search for a free block of at least size
    logic        find_addr;  // search for a block with matching data address
    logic [31:0] size;
    logic [31:0] addr;
    logic [7:0]  hdr;
  } scan_t;

  // What a cell reports back when its entry is hit.
  typedef struct packed {
    logic            fit_hit;
    logic            addr_hit;
    logic [IdxW-1:0] idx;
    logic [31:0]     start;
    logic [31:0]     size;
    logic            free;
  } hit_t;

  // Command from the controller to one cell.
  typedef struct packed {
    logic            wr;       // append entry
    logic            set_free;
    logic            clr_free;
    logic [IdxW-1:0] idx;
    logic [31:0]     start;
    logic [31:0]     size;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/first_fit_block_allocator.sv =====
`default_nettype none
// Scans: an allocate runs one fit scan down the chain of cells, a free one
//   address scan, and a growing realloc scans twice (address, then fit).
// Throughput: one transaction at a time; busy is high from acceptance through
//   the one-cycle result strobe, which the receiver cannot stall.
// Reset: asynchronous, active low; clears counts, break and configuration
//   to their reset values. Table entries need no clearing.
module first_fit_block_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] request_size_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [2:0]       status_o,
  output logic [31:0]      data_address_o,
  output logic [6:0]       free_blocks_o,
  output logic [31:0]      spare_bytes_o,
  output logic [6:0]       used_blocks_o,
  output logic [31:0]      used_bytes_o
);

  localparam int unsigned N = ffba_pkg::MaxBlocks;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ADDR   = 5'b00010,
    S_FIT    = 5'b00100,
    S_APPEND = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q;

  logic [31:0] max_req_q, limit_q;
  logic [7:0]  hdr_q;
  logic [1:0]  kind_q;
  logic [31:0] addr_q, size_q;
  logic [ffba_pkg::CntW-1:0] count_q, fcount_q;
  logic [31:0] brk_q, ftot_q, utot_q;
  logic [ffba_pkg::CntW-1:0] steps_q;
  logic        old_ok_q;
  logic [ffba_pkg::IdxW-1:0] old_idx_q;
  logic [31:0] old_size_q;
  logic [2:0]  st_q;
  logic [31:0] res_addr_q;
  logic        rv_q;

  ffba_pkg::scan_t chain [N+1];
  ffba_pkg::hit_t  hits  [N];
  ffba_pkg::cmd_t  cmd;
  ffba_pkg::scan_t inject;

  logic any_hit;
  ffba_pkg::hit_t hit_sel;
  logic [33:0] end_w;
  logic size_ok;
  logic need_lookup;

  assign chain[0] = inject;

  // Row of table cells; the search token moves one cell per cycle.
  for (genvar g = 0; g < N; g++) begin : g_cell
    ffba_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_idx_i (ffba_pkg::IdxW'(g)),
      .live_i   (ffba_pkg::CntW'(g) < count_q),
      .cmd_i    (cmd),
      .scan_i   (chain[g]),
      .scan_o   (chain[g+1]),
      .hit_o    (hits[g])
    );
  end

  // Only the cell holding the token can hit, so a loop that keeps the last hit selects it.
  always_comb begin
    any_hit = 1'b0;
    hit_sel = '0;
    for (int k = 0; k < N; k++) begin
      if (hits[k].fit_hit || hits[k].addr_hit) begin
        any_hit = 1'b1;
        hit_sel = hits[k];
      end
    end
  end

  assign size_ok = (size_q != 32'd0) && (size_q <= max_req_q);
  assign end_w = {2'b0, brk_q} + {26'd0, hdr_q} + {2'b0, size_q};

  // An address search is only run for a free or realloc that names a block (a realloc also needs a valid size).
  assign need_lookup = (kind_q == ffba_pkg::KindFree && addr_q != 32'd0) ||
                       (kind_q == ffba_pkg::KindRealloc && addr_q != 32'd0 && size_ok);

  // Controller.
  always_comb begin
    inject  = '0;
    cmd     = '0;
    cmd.start = brk_q;
    cmd.size  = size_q;
    unique case (state_q)
      S_ADDR, S_FIT: begin
        if (steps_q == '0 && (state_q == S_FIT || need_lookup)) begin
          inject.valid     = 1'b1;
          inject.find_fit  = (state_q == S_FIT);
          inject.find_addr = (state_q == S_ADDR);
          inject.size      = size_q;
          inject.addr      = addr_q;
          inject.hdr       = hdr_q;
        end
        if (state_q == S_FIT && any_hit) begin
          cmd.clr_free = 1'b1;
          cmd.idx      = hit_sel.idx;
        end
      end
      S_APPEND: begin
        cmd.wr  = 1'b1;
        cmd.idx = count_q[ffba_pkg::IdxW-1:0];
      end
      S_DONE: begin
        if (old_ok_q) begin
          cmd.set_free = 1'b1;
          cmd.idx      = old_idx_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      max_req_q  <= ffba_pkg::ResetMaxRequest;
      hdr_q      <= ffba_pkg::ResetHeaderBytes;
      limit_q    <= ffba_pkg::ResetHeapLimit;
      kind_q     <= ffba_pkg::KindAlloc;
      addr_q     <= '0;
      size_q     <= '0;
      count_q    <= '0;
      fcount_q   <= '0;
      brk_q      <= '0;
      ftot_q     <= '0;
      utot_q     <= '0;
      steps_q    <= '0;
      old_ok_q   <= 1'b0;
      old_idx_q  <= '0;
      old_size_q <= '0;
      st_q       <= ffba_pkg::StReused;
      res_addr_q <= '0;
      rv_q       <= 1'b0;
    end else begin
      rv_q <= 1'b0;
      // Configuration writes.
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ffba_pkg::CfgMaxRequest:  max_req_q <= cfg_data_i;
          ffba_pkg::CfgHeaderBytes: hdr_q     <= cfg_data_i[7:0];
          ffba_pkg::CfgHeapLimit:   limit_q   <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (start && !busy) begin
            kind_q   <= kind_i;
            addr_q   <= address_i;
            size_q   <= request_size_i;
            steps_q  <= '0;
            old_ok_q <= 1'b0;
            state_q  <= S_ADDR;
          end
        end
        S_ADDR: begin
          steps_q <= steps_q + 1'b1;
          if (steps_q == '0 && (kind_q == ffba_pkg::KindAlloc ||
              (kind_q == ffba_pkg::KindRealloc && addr_q == 32'd0))) begin
            // No address lookup needed.
            steps_q <= '0;
            if (kind_q == ffba_pkg::KindAlloc && !size_ok || kind_q == ffba_pkg::KindRealloc
                && !size_ok) begin
              st_q <= ffba_pkg::StBadSize; state_q <= S_DONE;
            end else state_q <= S_FIT;
          end else if (steps_q == '0 && (kind_q == ffba_pkg::KindUnused ||
                       (kind_q == ffba_pkg::KindRealloc && !size_ok))) begin
            st_q <= ffba_pkg::StBadSize; state_q <= S_DONE;
          end else if (steps_q == '0 && kind_q == ffba_pkg::KindFree && addr_q == 32'd0) begin
            st_q <= ffba_pkg::StFreed; res_addr_q <= '0; state_q <= S_DONE;
          end else if (any_hit) begin
            steps_q <= '0;
            if (kind_q == ffba_pkg::KindFree) begin
              st_q <= ffba_pkg::StFreed; res_addr_q <= '0;
              if (!hit_sel.free) begin
                old_ok_q <= 1'b1; old_idx_q <= hit_sel.idx;
                fcount_q <= fcount_q + 1'b1; ftot_q <= ftot_q + hit_sel.size;
              end
              state_q <= S_DONE;
            end else if (hit_sel.free) begin
              st_q <= ffba_pkg::StNotFound; state_q <= S_DONE;
            end else if (hit_sel.size >= size_q) begin
              st_q <= ffba_pkg::StKept; res_addr_q <= addr_q; state_q <= S_DONE;
            end else begin
              old_idx_q <= hit_sel.idx; old_size_q <= hit_sel.size;
              state_q <= S_FIT;
            end
          end else if (steps_q == ffba_pkg::CntW'(N) + 1'b1) begin
            st_q <= ffba_pkg::StNotFound; state_q <= S_DONE;
          end
        end
        S_FIT: begin
          steps_q <= steps_q + 1'b1;
          if (any_hit) begin
            fcount_q <= fcount_q - 1'b1; ftot_q <= ftot_q - hit_sel.size;
            st_q <= ffba_pkg::StReused;
            res_addr_q <= hit_sel.start + {24'd0, hdr_q};
            if (kind_q == ffba_pkg::KindRealloc && addr_q != 32'd0) old_ok_q <= 1'b1;
            state_q <= S_DONE;
          end else if (steps_q == ffba_pkg::CntW'(N) + 1'b1) begin
            if (count_q >= ffba_pkg::CntW'(N)) begin
              st_q <= ffba_pkg::StTableFull; state_q <= S_DONE;
            end else if (end_w > {2'b0, limit_q}) begin
              st_q <= ffba_pkg::StExhausted; state_q <= S_DONE;
            end else state_q <= S_APPEND;
          end
        end
        S_APPEND: begin
          count_q <= count_q + 1'b1;
          utot_q  <= utot_q + size_q;
          brk_q   <= end_w[31:0];
          st_q    <= ffba_pkg::StAppended;
          res_addr_q <= brk_q + {24'd0, hdr_q};
          if (kind_q == ffba_pkg::KindRealloc && addr_q != 32'd0) old_ok_q <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Realloc frees its old block only after the new grant.
          if (old_ok_q && kind_q == ffba_pkg::KindRealloc) begin
            fcount_q <= fcount_q + 1'b1; ftot_q <= ftot_q + old_size_q;
          end
          old_ok_q <= 1'b0;
          rv_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE) || rv_q;
  assign result_valid_o = rv_q;
  assign status_o       = st_q;
  assign data_address_o = (st_q > ffba_pkg::StFreed) ? 32'd0 : res_addr_q;
  assign free_blocks_o  = 7'(fcount_q);
  assign spare_bytes_o  = ftot_q;
  assign used_blocks_o  = 7'(count_q);
  assign used_bytes_o   = utot_q;

  // A result strobe always follows the completion state.
  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> result_valid_o) else $error("missing result strobe");
  // Free blocks never outnumber table blocks.
  a_free_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= count_q) else $error("free count exceeds block count");
  // Appending grows the table by exactly one.
  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPEND) |=> (count_q == $past(count_q) + 1'b1))
    else $error("append did not grow table");

endmodule
`default_nettype wire

// ===== rtl/core/ffba_cell.sv =====
`default_nettype none
module ffba_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [ffba_pkg::IdxW-1:0] my_idx_i,
  input  wire logic                   live_i,
  input  wire ffba_pkg::cmd_t         cmd_i,
  input  wire ffba_pkg::scan_t        scan_i,
  output ffba_pkg::scan_t             scan_o,
  output ffba_pkg::hit_t              hit_o
);

  logic [31:0] start_q;
  logic [31:0] size_q;
  logic        free_q;
  ffba_pkg::scan_t scan_q, scan_d;
  logic        fit, match;

  // Entry storage, written only by commands addressed to this cell.
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx == my_idx_i) begin
      if (cmd_i.wr) begin
        start_q <= cmd_i.start;
        size_q  <= cmd_i.size;
        free_q  <= 1'b0;
      end else if (cmd_i.set_free) begin
        free_q <= 1'b1;
      end else if (cmd_i.clr_free) begin
        free_q <= 1'b0;
      end
    end
  end

  // Compare the passing token against this entry.
  always_comb begin
    fit   = scan_i.valid && scan_i.find_fit && live_i && free_q && (size_q >= scan_i.size);
    match = scan_i.valid && scan_i.find_addr && live_i &&
            ((start_q + {24'd0, scan_i.hdr}) == scan_i.addr);
    hit_o.fit_hit  = fit;
    hit_o.addr_hit = match;
    hit_o.idx      = my_idx_i;
    hit_o.start    = start_q;
    hit_o.size     = size_q;
    hit_o.free     = free_q;
    scan_d         = scan_i;
    // A found token stops here.
    if (fit || match) scan_d.valid = 1'b0;
  end

  // Hand the token to the neighbor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_first_fit_block_allocator.sv =====
`timescale 1ns / 100ps
module tb_first_fit_block_allocator;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  // One request transaction and one expected answer.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] size;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] data_address;
    logic [6:0]  free_blocks;
    logic [31:0] spare_bytes;
    logic [6:0]  used_blocks;
    logic [31:0] used_bytes;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  kind_i;
  logic [31:0] address_i;
  logic [31:0] request_size_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [31:0] data_address_o;
  logic [6:0]  free_blocks_o;
  logic [31:0] spare_bytes_o;
  logic [6:0]  used_blocks_o;
  logic [31:0] used_bytes_o;

  first_fit_block_allocator DUT (.*);

  // Shadow copy of the allocator state.
  logic [31:0] mdl_max_request;
  logic [7:0]  mdl_header;
  logic [31:0] mdl_heap_limit;
  logic [31:0] mdl_start [ffba_pkg::MaxBlocks];
  logic [31:0] mdl_size [ffba_pkg::MaxBlocks];
  logic        mdl_free [ffba_pkg::MaxBlocks];
  int unsigned mdl_count;
  logic [31:0] mdl_break;
  logic [6:0]  mdl_free_count;
  logic [31:0] mdl_free_total;
  logic [31:0] mdl_used_total;

  request_t    pending_requests[$];
  answer_t     expected_answers[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          in_flight;
  int unsigned send_gap;
  logic        busy_at_edge;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [31:0] data_of(int unsigned i);
    return mdl_start[i] + {24'd0, mdl_header};
  endfunction

  function automatic int find_data_addr(logic [31:0] a);
    for (int unsigned i = 0; i < mdl_count; i++) begin
      if (data_of(i) == a) return i;
    end
    return -1;
  endfunction

  function automatic void release_block(int unsigned i);
    if (!mdl_free[i]) begin
      mdl_free[i] = 1'b1;
      mdl_free_count++;
      mdl_free_total += mdl_size[i];
    end
  endfunction

  // First-fit search, then append at the break.
  function automatic logic [2:0] grant_block(logic [31:0] sz, output logic [31:0] a);
    logic [33:0] heap_end;
    a = '0;
    for (int unsigned i = 0; i < mdl_count; i++) begin
      if (mdl_free[i] && mdl_size[i] >= sz) begin
        mdl_free[i] = 1'b0;
        mdl_free_count--;
        mdl_free_total -= mdl_size[i];
        a = data_of(i);
        return ffba_pkg::StReused;
      end
    end
    if (mdl_count >= ffba_pkg::MaxBlocks) return ffba_pkg::StTableFull;
    heap_end = {2'b0, mdl_break} + {26'd0, mdl_header} + {2'b0, sz};
    if (heap_end > {2'b0, mdl_heap_limit}) return ffba_pkg::StExhausted;
    mdl_start[mdl_count] = mdl_break;
    mdl_size[mdl_count] = sz;
    mdl_free[mdl_count] = 1'b0;
    a = data_of(mdl_count);
    mdl_count++;
    mdl_used_total += sz;
    mdl_break = heap_end[31:0];
    return ffba_pkg::StAppended;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t     ans;
    logic [31:0] a;
    int          idx;
    bit          size_ok;
    a = '0;
    ans.status = ffba_pkg::StBadSize;
    size_ok = r.size != 0 && r.size <= mdl_max_request;
    if (r.kind == ffba_pkg::KindAlloc) begin
      if (size_ok) ans.status = grant_block(r.size, a);
    end else if (r.kind == ffba_pkg::KindFree) begin
      if (r.address == 0) begin
        ans.status = ffba_pkg::StFreed;
      end else begin
        idx = find_data_addr(r.address);
        if (idx >= 0) begin
          release_block(idx);
          ans.status = ffba_pkg::StFreed;
        end else begin
          ans.status = ffba_pkg::StNotFound;
        end
      end
    end else if (r.kind == ffba_pkg::KindRealloc) begin
      idx = find_data_addr(r.address);
      if (!size_ok) ans.status = ffba_pkg::StBadSize;
      else if (r.address == 0) ans.status = grant_block(r.size, a);
      else if (idx < 0 || mdl_free[idx]) ans.status = ffba_pkg::StNotFound;
      else if (mdl_size[idx] >= r.size) begin
        ans.status = ffba_pkg::StKept;
        a = r.address;
      end else begin
        ans.status = grant_block(r.size, a);
        if (ans.status == ffba_pkg::StReused || ans.status == ffba_pkg::StAppended)
          release_block(idx);
      end
    end
    if (ans.status > ffba_pkg::StFreed) a = '0;
    ans.data_address = a;
    ans.free_blocks = mdl_free_count;
    ans.spare_bytes = mdl_free_total;
    ans.used_blocks = mdl_count[6:0];
    ans.used_bytes = mdl_used_total;
    return ans;
  endfunction

  // Driver: one transaction at a time, random gap before each.
  always @(negedge clk_i) begin
    if (!rst_ni || cfg_we_i) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      start <= 1'b0;
    end else if (!start && !in_flight && pending_requests.size() > 0) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else begin
        kind_i <= pending_requests[0].kind;
        address_i <= pending_requests[0].address;
        request_size_i <= pending_requests[0].size;
        start <= 1'b1;
        send_gap <= $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk_i) busy_at_edge <= busy;

  // Acceptance: predict on the edge that takes the transaction.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      expected_answers.push_back(predict_answer(pending_requests.pop_front()));
      in_flight <= 1'b1;
      idle_cycles <= 0;
    end else if (rst_ni && result_valid_o) begin
      in_flight <= 1'b0;
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Monitor: compare each result strobe with the oldest expectation.
  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && result_valid_o) begin
      if (expected_answers.size() == 0) begin
        $error("result with no transaction outstanding");
        error_count++;
      end else begin
        exp_ans = expected_answers.pop_front();
        if (status_o !== exp_ans.status) begin
          $error("status exp %0d got %0d", exp_ans.status, status_o);
          error_count++;
        end
        if (data_address_o !== exp_ans.data_address) begin
          $error("data_address exp %0h got %0h", exp_ans.data_address, data_address_o);
          error_count++;
        end
        if (free_blocks_o !== exp_ans.free_blocks) begin
          $error("free_blocks exp %0d got %0d", exp_ans.free_blocks, free_blocks_o);
          error_count++;
        end
        if (spare_bytes_o !== exp_ans.spare_bytes) begin
          $error("spare_bytes exp %0d got %0d", exp_ans.spare_bytes, spare_bytes_o);
          error_count++;
        end
        if (used_blocks_o !== exp_ans.used_blocks) begin
          $error("used_blocks exp %0d got %0d", exp_ans.used_blocks, used_blocks_o);
          error_count++;
        end
        if (used_bytes_o !== exp_ans.used_bytes) begin
          $error("used_bytes exp %0d got %0d", exp_ans.used_bytes, used_bytes_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction or result.
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_requests.size() > 0 || expected_answers.size() > 0 || in_flight || start)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ffba_pkg::CfgMaxRequest) mdl_max_request = val;
    else if (idx == ffba_pkg::CfgHeaderBytes) mdl_header = val[7:0];
    else if (idx == ffba_pkg::CfgHeapLimit) mdl_heap_limit = val;
  endtask

  task automatic queue_req(logic [1:0] k, logic [31:0] a, logic [31:0] s);
    request_t r;
    r.kind = k;
    r.address = a;
    r.size = s;
    pending_requests.push_back(r);
  endtask

  // Address biased towards live data addresses so free and realloc find blocks.
  function automatic logic [31:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'd0;
    if (roll == 1 || mdl_count == 0) return $urandom();
    if (roll == 2) return data_of($urandom_range(0, mdl_count - 1)) + 32'd1;
    return data_of($urandom_range(0, mdl_count - 1));
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 32'd0;
    if (roll == 1) return $urandom();
    if (roll == 2) return mdl_max_request;
    if (roll < 8) return $urandom_range(1, 64);
    return $urandom_range(1, 4096);
  endfunction

  // Random phase: requests are queued one at a time so that addresses track
  // the table as it stands when each transaction is predicted.
  task automatic random_phase(int unsigned n);
    int unsigned roll;
    logic [1:0]  k;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      k = roll < 45 ? ffba_pkg::KindAlloc : roll < 75 ? ffba_pkg::KindFree :
          roll < 98 ? ffba_pkg::KindRealloc : ffba_pkg::KindUnused;
      while (pending_requests.size() > 0) @(posedge clk_i);
      queue_req(k, pick_address(), pick_size());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = '0;
    address_i = '0;
    request_size_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    error_count = 0;
    idle_cycles = 0;
    in_flight = 1'b0;
    send_gap = 0;
    mdl_max_request = ffba_pkg::ResetMaxRequest;
    mdl_header = ffba_pkg::ResetHeaderBytes;
    mdl_heap_limit = ffba_pkg::ResetHeapLimit;
    mdl_count = 0;
    mdl_break = '0;
    mdl_free_count = '0;
    mdl_free_total = '0;
    mdl_used_total = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset configuration, each kind and each corner.
    queue_req(ffba_pkg::KindAlloc, 0, 0);
    queue_req(ffba_pkg::KindAlloc, 0, 100);
    queue_req(ffba_pkg::KindAlloc, 0, 200);
    queue_req(ffba_pkg::KindFree, 40, 0);
    queue_req(ffba_pkg::KindFree, 40, 0);
    queue_req(ffba_pkg::KindAlloc, 0, 50);
    queue_req(ffba_pkg::KindFree, 0, 0);
    queue_req(ffba_pkg::KindFree, 32'hFFFF_FFFF, 0);
    queue_req(ffba_pkg::KindRealloc, 180, 150);
    queue_req(ffba_pkg::KindRealloc, 180, 500);
    queue_req(ffba_pkg::KindRealloc, 180, 10);
    queue_req(ffba_pkg::KindRealloc, 0, 20);
    queue_req(ffba_pkg::KindAlloc, 0, 100000001);
    queue_req(ffba_pkg::KindAlloc, 0, 32'hFFFF_FFFF);
    queue_req(ffba_pkg::KindAlloc, 0, 100000000);
    queue_req(ffba_pkg::KindUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(ffba_pkg::KindRealloc, 40, 5000000);
    wait_idle();

    // Phases over different register settings, extremes included.
    write_reg(ffba_pkg::CfgHeaderBytes, 8'd0);
    write_reg(ffba_pkg::CfgMaxRequest, 32'hFFFF_FFFF);
    write_reg(ffba_pkg::CfgHeapLimit, 32'hFFFF_FFFF);
    queue_req(ffba_pkg::KindAlloc, 0, 32'hFFFF_FF00);
    random_phase(350);
    write_reg(ffba_pkg::CfgHeaderBytes, 8'd255);
    write_reg(ffba_pkg::CfgMaxRequest, 32'd1);
    random_phase(100);
    write_reg(ffba_pkg::CfgMaxRequest, 32'd300);
    write_reg(ffba_pkg::CfgHeapLimit, 32'd0);
    random_phase(100);
    write_reg(ffba_pkg::CfgHeapLimit, 32'hFFFF_FFFF);
    write_reg(ffba_pkg::CfgHeaderBytes, 8'd16);
    random_phase(500);
    write_reg(ffba_pkg::CfgMaxRequest, 32'd100000000);
    write_reg(ffba_pkg::CfgHeaderBytes, 8'd40);
    write_reg(ffba_pkg::CfgHeapLimit, 32'd1048576);
    random_phase(580);

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
